@@ src/catru_pkg.sv @@
// Shared types, constants and the CSR number lookup for the CSR access and trap return unit.
package catru_pkg;

  localparam int NumCsrs = 35;
  localparam int CsrIdxW = $clog2(NumCsrs);

  // Action codes.
  localparam logic [1:0] ACT_CSR  = 2'd0;
  localparam logic [1:0] ACT_MRET = 2'd1;
  localparam logic [1:0] ACT_SRET = 2'd2;

  // funct3 codes and the operation kind in its low two bits.
  localparam logic [2:0] F3_ILL0 = 3'd0;
  localparam logic [2:0] F3_ILL4 = 3'd4;
  localparam logic [1:0] OP_RW   = 2'd1;
  localparam logic [1:0] OP_RS   = 2'd2;

  // Privilege levels.
  localparam logic [1:0] PRIV_U = 2'd0;
  localparam logic [1:0] PRIV_S = 2'd1;
  localparam logic [1:0] PRIV_M = 2'd3;

  // Storage slots of the CSRs that trap return touches.
  localparam logic [CsrIdxW-1:0] IDX_SEPC    = CsrIdxW'(8);
  localparam logic [CsrIdxW-1:0] IDX_MSTATUS = CsrIdxW'(13);
  localparam logic [CsrIdxW-1:0] IDX_MEPC    = CsrIdxW'(21);

  // mstatus bit positions.
  localparam int ST_SIE  = 1;
  localparam int ST_MIE  = 3;
  localparam int ST_SPIE = 5;
  localparam int ST_MPIE = 7;
  localparam int ST_SPP  = 8;
  localparam int ST_MPPL = 11;
  localparam int ST_MPPH = 12;

  localparam logic [11:0] CsrAddrTable [NumCsrs] = '{
    12'h001, 12'h002, 12'h003,
    12'h100, 12'h106, 12'h104, 12'h105, 12'h140, 12'h141, 12'h142, 12'h143, 12'h144,
    12'h180,
    12'h300, 12'h301, 12'h306, 12'h302, 12'h303, 12'h304, 12'h305, 12'h340, 12'h341,
    12'h342, 12'h343, 12'h344,
    12'hC00, 12'hC01, 12'hC02, 12'hC80, 12'hC81, 12'hC82,
    12'hF11, 12'hF12, 12'hF13, 12'hF14
  };

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] csr_number;
    logic [2:0]  funct3;
    logic [4:0]  source_index;
    logic [31:0] source_value;
    logic [4:0]  dest_index;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic        dest_write;
    logic [4:0]  dest_number;
    logic [31:0] dest_value;
    logic        redirect;
    logic [31:0] target_pc;
    logic [1:0]  privilege_after;
  } rsp_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic capture;
    logic decode;
    logic read;
    logic exec;
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic legal;
  } status_t;

  // Returns {hit, slot} for a CSR number; the table entries are all distinct.
  function automatic logic [CsrIdxW:0] csr_lookup(logic [11:0] num);
    logic             hit;
    logic [CsrIdxW-1:0] idx;
    hit = 1'b0;
    idx = '0;
    for (int i = 0; i < NumCsrs; i++) begin
      if (CsrAddrTable[i] == num) begin
        hit = 1'b1;
        idx = CsrIdxW'(i);
      end
    end
    return {hit, idx};
  endfunction

endpackage

@@ src/catru_ctrl.sv @@
// Sequencer of the CSR access and trap return unit.
module catru_ctrl import catru_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_EXEC
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (start) state_d = S_DECODE;
      // Illegal requests need no CSR read.
      S_DECODE: state_d = status_i.legal ? S_READ : S_EXEC;
      S_READ:   state_d = S_EXEC;
      S_EXEC:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign cmd_o.capture = (state_q == S_IDLE) && start;
  assign cmd_o.decode  = (state_q == S_DECODE);
  assign cmd_o.read    = (state_q == S_READ);
  assign cmd_o.exec    = (state_q == S_EXEC);

endmodule

@@ src/catru_datapath.sv @@
// Datapath of the CSR access and trap return unit: CSR file, privilege and result register.
module catru_datapath import catru_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  input  req_t    req_i,
  output status_t status_o,
  output logic    rsp_valid_o,
  output rsp_t    rsp_o
);

  req_t               req_q;
  logic [CsrIdxW-1:0] idx_q;
  logic               legal_q;
  logic [1:0]         priv_q, priv_d;
  logic [31:0]        rdata_a_q, rdata_b_q;
  logic               rsp_valid_q;
  rsp_t               rsp_q, rsp_d;

  logic [31:0]        mem [NumCsrs];
  logic [NumCsrs-1:0] valid_q;

  logic [CsrIdxW:0]   lookup;
  logic               legal;
  logic [CsrIdxW-1:0] raddr_a, raddr_b;
  logic               mem_we;
  logic [CsrIdxW-1:0] mem_wa;
  logic [31:0]        mem_wd;
  logic [31:0]        src;
  logic [31:0]        st;

  // Decode: look up the number and check legality; only returns depend on privilege.
  always_comb begin
    lookup = csr_lookup(req_q.csr_number);
    unique case (req_q.action)
      ACT_CSR:  legal = lookup[CsrIdxW] && (req_q.funct3 != F3_ILL0) &&
                        (req_q.funct3 != F3_ILL4);
      ACT_MRET: legal = (priv_q == PRIV_M);
      ACT_SRET: legal = (priv_q != PRIV_U);
      default:  legal = 1'b0;
    endcase
  end

  assign status_o.legal = legal;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= req_i;
    if (cmd_i.decode) begin
      idx_q   <= lookup[CsrIdxW-1:0];
      legal_q <= legal;
    end
  end

  assign raddr_a = (req_q.action == ACT_CSR)  ? idx_q    : IDX_MSTATUS;
  assign raddr_b = (req_q.action == ACT_MRET) ? IDX_MEPC : IDX_SEPC;

  // CSR file; entries never written read as zero.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd_i.read) begin
      rdata_a_q <= valid_q[raddr_a] ? mem[raddr_a] : '0;
      rdata_b_q <= valid_q[raddr_b] ? mem[raddr_b] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (mem_we) begin
      valid_q[mem_wa] <= 1'b1;
    end
  end

  // Execute.
  always_comb begin
    src    = req_q.funct3[2] ? {27'd0, req_q.source_index} : req_q.source_value;
    st     = rdata_a_q;
    mem_we = 1'b0;
    mem_wa = raddr_a;
    mem_wd = '0;
    priv_d = priv_q;
    rsp_d  = '0;
    if (legal_q) begin
      rsp_d.accepted = 1'b1;
      case (req_q.action)
        ACT_CSR: begin
          if (req_q.funct3[1:0] == OP_RW) begin
            mem_we = 1'b1;
            mem_wd = src;
          end else if (req_q.source_index != 5'd0) begin
            mem_we = 1'b1;
            mem_wd = (req_q.funct3[1:0] == OP_RS) ? (rdata_a_q | src) : (rdata_a_q & ~src);
          end
          if (req_q.dest_index != 5'd0) begin
            rsp_d.dest_write  = 1'b1;
            rsp_d.dest_number = req_q.dest_index;
            rsp_d.dest_value  = rdata_a_q;
          end
        end
        ACT_MRET: begin
          priv_d                = st[ST_MPPH:ST_MPPL];
          st[ST_MIE]            = st[ST_MPIE];
          st[ST_MPIE]           = 1'b1;
          st[ST_MPPH:ST_MPPL]   = 2'b00;
          mem_we                = 1'b1;
          mem_wd                = st;
          rsp_d.redirect        = 1'b1;
          rsp_d.target_pc       = {rdata_b_q[31:1], 1'b0};
        end
        default: begin
          priv_d                = st[ST_SPP] ? PRIV_S : PRIV_U;
          st[ST_SIE]            = st[ST_SPIE];
          st[ST_SPIE]           = 1'b1;
          st[ST_SPP]            = 1'b0;
          mem_we                = 1'b1;
          mem_wd                = st;
          rsp_d.redirect        = 1'b1;
          rsp_d.target_pc       = {rdata_b_q[31:1], 1'b0};
        end
      endcase
      mem_we = mem_we && cmd_i.exec;
    end
    rsp_d.privilege_after = priv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      priv_q      <= PRIV_M;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= cmd_i.exec;
      if (cmd_i.exec) priv_q <= priv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

@@ src/csr_access_and_trap_return_unit.sv @@
// Top level of the CSR access and trap return unit.
//
// This unit executes one system instruction per request: a CSR access (RW, RS, RC and
// their immediate forms), an MRET or an SRET, against a file of 35 implemented CSRs
// and the current privilege level, which resets to machine mode with all CSRs zero.
// A request is taken at a rising edge where start is high and busy is low. The
// sequencer steps a legal request through decode, a read of the CSR file with
// registered read data, and execute with write-back; an illegal one skips the read.
// The result appears on rsp_o, marked by rsp_valid_o for exactly one cycle, and the
// receiver cannot stall it. busy drops in the cycle the result is shown, so the next
// request may be issued alongside it.
module csr_access_and_trap_return_unit import catru_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  cmd_t    cmd;
  status_t status;

  // The sequencer steps each request through its phases.
  catru_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // The datapath holds the captured request, the CSR file and the result register.
  catru_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .status_o    (status),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

@@ src/catru_checker.sv @@
// Port-level checker for the CSR access and trap return unit, with its bind.
module catru_checker import catru_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input req_t req_i,
  input logic busy,
  input logic rsp_valid_o,
  input rsp_t rsp_o
);

  // A taken request keeps the unit busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("request taken but unit not busy");

  // Results never come back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni) rsp_valid_o |=> !rsp_valid_o)
    else $error("two results in consecutive cycles");

  // An illegal instruction neither writes rd nor redirects.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_o.accepted) |-> (!rsp_o.dest_write && !rsp_o.redirect))
    else $error("illegal instruction with side effects");

  // A return target is halfword aligned.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.redirect) |-> !rsp_o.target_pc[0])
    else $error("return target has bit 0 set");

  // x0 is never a destination.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.dest_write) |-> (rsp_o.dest_number != 5'd0))
    else $error("write to x0 requested");

endmodule

bind csr_access_and_trap_return_unit catru_checker u_catru_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .req_i       (req_i),
  .busy        (busy),
  .rsp_valid_o (rsp_valid_o),
  .rsp_o       (rsp_o)
);
